@@ hdl/ghp_pkg.sv @@
package ghp_pkg;

  // pool geometry
  localparam int HP_SLOTS = 256;
  localparam int HP_IDX_W = 8;
  localparam logic [8:0] HP_FREE_EMPTY = 9'd511;

  // operation codes
  typedef enum logic [2:0] {
    OP_ALLOC        = 3'd0,
    OP_FREE         = 3'd1,
    OP_CHECK_HANDLE = 3'd2,
    OP_CHECK_INDEX  = 3'd3,
    OP_FIND_NEXT    = 3'd4,
    OP_FREE_ALL     = 3'd5
  } ghp_op_t;

  // result status codes
  typedef enum logic [1:0] {
    RS_OK    = 2'd0,
    RS_FULL  = 2'd1,
    RS_STALE = 2'd2,
    RS_RANGE = 2'd3
  } ghp_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE      = 2'd0,
    S_EXEC      = 2'd1,
    S_SCAN_FIND = 2'd2,
    S_SCAN_FREE = 2'd3
  } ghp_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic find_step;
    logic free_step;
    logic commit;
  } ghp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic scan_hit;
  } ghp_stat_t;

endpackage

@@ hdl/ghp_ctrl.sv @@
module ghp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0]         operation,
  output logic               in_stall,
  input  ghp_pkg::ghp_stat_t stat,
  output ghp_pkg::ghp_cmd_t  cmd
);
  import ghp_pkg::*;

  ghp_state_t state;
  ghp_state_t state_next;
  ghp_op_t    in_op;

  assign in_op = ghp_op_t'(operation);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_FIND_NEXT: state_next = S_SCAN_FIND;
            OP_FREE_ALL:  state_next = S_SCAN_FREE;
            default:      state_next = S_EXEC;
          endcase
        end
      end
      S_SCAN_FIND: begin
        if (stat.scan_done || stat.scan_hit) state_next = S_EXEC;
      end
      S_SCAN_FREE: begin
        if (stat.scan_done) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd           = '0;
    in_stall      = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_SCAN_FIND: cmd.find_step = 1'b1;
      S_SCAN_FREE: cmd.free_step = 1'b1;
      S_EXEC:      cmd.commit = stat.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

@@ hdl/ghp_datapath.sv @@
module ghp_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ghp_pkg::ghp_cmd_t  cmd,
  output ghp_pkg::ghp_stat_t stat,
  input  logic [2:0]         operation,
  input  logic [63:0]        handle,
  input  logic [7:0]         slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [63:0]        handle_out,
  output logic [7:0]         index_out,
  output logic [8:0]         live_count
);
  import ghp_pkg::*;

  // key and free-list link memories
  logic [31:0] key_mem  [HP_SLOTS];
  logic [8:0]  link_mem [HP_SLOTS];
  logic [31:0] key_rdata;
  logic [8:0]  link_rdata;

  // slot state and pool registers
  logic [HP_SLOTS-1:0] alloc;
  logic [8:0]          free_head;
  logic [8:0]          high_water;
  logic [31:0]         next_key;
  logic [8:0]          used_count;
  logic [8:0]          cursor;
  logic                found;

  // latched beat
  ghp_op_t     op_q;
  logic [63:0] handle_q;
  logic [7:0]  si_q;

  ghp_op_t           in_op;
  logic [7:0]        hidx;
  logic [31:0]       key_h;
  logic [31:0]       key_eff;
  logic              range_h;
  logic              scan_done;
  logic              scan_hit;
  logic              from_list;
  logic              can_grow;
  logic              out_free;
  ghp_status_t       res_status;
  logic [63:0]       res_handle;
  logic [7:0]        res_index;
  logic [8:0]        res_live;
  logic              do_alloc;
  logic              do_free;
  logic [7:0]        new_idx;
  logic              rel;
  logic [7:0]        rel_idx;
  logic              key_re;
  logic [7:0]        key_raddr;
  logic [31:0]       next_key_next;

  assign in_op     = ghp_op_t'(operation);
  assign hidx      = handle_q[7:0];
  assign key_h     = handle_q[63:32];
  assign key_eff   = alloc[hidx] ? key_rdata : 32'd0;
  assign range_h   = handle_q[31:0] >= {23'd0, high_water};
  assign scan_done = cursor >= high_water;
  assign scan_hit  = !scan_done && alloc[cursor[7:0]];
  assign from_list = free_head < 9'(HP_SLOTS);
  assign can_grow  = high_water < 9'(HP_SLOTS);
  assign out_free  = !out_valid || !out_stall;

  assign stat.out_free  = out_free;
  assign stat.scan_done = scan_done;
  assign stat.scan_hit  = scan_hit;

  assign next_key_next = (next_key == 32'hFFFF_FFFF) ? 32'd1 : next_key + 32'd1;

  // result and update decisions for the latched operation
  always_comb begin
    res_status = RS_OK;
    res_handle = '0;
    res_index  = '0;
    do_alloc   = 1'b0;
    do_free    = 1'b0;
    new_idx    = from_list ? free_head[7:0] : high_water[7:0];
    case (op_q)
      OP_ALLOC: begin
        if (from_list || can_grow) begin
          do_alloc   = 1'b1;
          res_handle = {next_key, 24'd0, new_idx};
          res_index  = new_idx;
        end else begin
          res_status = RS_FULL;
        end
      end
      OP_FREE, OP_CHECK_HANDLE: begin
        if (range_h) begin
          res_status = RS_RANGE;
        end else if (key_h == 32'd0 || key_eff != key_h) begin
          res_status = RS_STALE;
        end else begin
          res_handle = handle_q;
          res_index  = hidx;
          do_free    = (op_q == OP_FREE);
        end
      end
      OP_CHECK_INDEX: begin
        if ({1'b0, si_q} >= high_water) begin
          res_status = RS_RANGE;
        end else if (!alloc[si_q]) begin
          res_status = RS_STALE;
        end else begin
          res_handle = {key_rdata, 24'd0, si_q};
          res_index  = si_q;
        end
      end
      OP_FIND_NEXT: begin
        if (found) begin
          res_handle = {key_rdata, 23'd0, cursor};
          res_index  = cursor[7:0];
        end else begin
          res_status = RS_RANGE;
        end
      end
      OP_FREE_ALL: res_status = RS_OK;
      default:     res_status = RS_RANGE;
    endcase
  end

  always_comb begin
    res_live = used_count;
    if (do_alloc) begin
      res_live = used_count + 9'd1;
    end else if (do_free) begin
      res_live = used_count - 9'd1;
    end
  end

  // slot release, from a single free or the free-all sweep
  assign rel     = (cmd.free_step && scan_hit) || (cmd.commit && do_free);
  assign rel_idx = cmd.free_step ? cursor[7:0] : hidx;

  // key read port address
  assign key_re    = cmd.accept || (cmd.find_step && scan_hit);
  assign key_raddr = cmd.accept ? ((in_op == OP_CHECK_INDEX) ? slot_index : handle[7:0])
                                : cursor[7:0];

  // memories
  always_ff @(posedge clk) begin
    if (key_re) key_rdata <= key_mem[key_raddr];
    if (cmd.commit && do_alloc) key_mem[new_idx] <= next_key;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) link_rdata <= link_mem[free_head[7:0]];
    if (rel) link_mem[rel_idx] <= free_head;
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= in_op;
      handle_q <= handle;
      si_q     <= slot_index;
    end
  end

  // pool control state
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc      <= '0;
      free_head  <= HP_FREE_EMPTY;
      high_water <= '0;
      next_key   <= 32'd1;
      used_count <= '0;
      cursor     <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cursor <= (in_op == OP_FREE_ALL) ? 9'd0 : {1'b0, slot_index};
        found  <= 1'b0;
      end
      if (cmd.find_step) begin
        if (scan_hit) begin
          found <= 1'b1;
        end else if (!scan_done) begin
          cursor <= cursor + 9'd1;
        end
      end
      if (cmd.free_step && !scan_done) cursor <= cursor + 9'd1;
      if (rel) begin
        alloc[rel_idx] <= 1'b0;
        free_head      <= {1'b0, rel_idx};
        used_count     <= used_count - 9'd1;
      end
      if (cmd.commit && do_alloc) begin
        alloc[new_idx] <= 1'b1;
        next_key       <= next_key_next;
        used_count     <= used_count + 9'd1;
        if (from_list) begin
          free_head <= link_rdata;
        end else begin
          high_water <= high_water + 9'd1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status     <= res_status;
      handle_out <= res_handle;
      index_out  <= res_index;
      live_count <= res_live;
    end
  end

`ifndef SYNTHESIS
  a_count_le_hw: assert property (@(posedge clk) disable iff (rst)
    used_count <= high_water) else $error("live count above high water");
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= 9'(HP_SLOTS)) else $error("high water beyond pool");
  a_head_sane: assert property (@(posedge clk) disable iff (rst)
    free_head == HP_FREE_EMPTY || free_head < high_water)
    else $error("free list head outside used slots");
  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_key != 32'd0) else $error("zero key pending");
  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_alloc |=> alloc[$past(new_idx)])
    else $error("allocated slot not marked");
`endif

endmodule

@@ hdl/generational_handle_pool_unit.sv @@
// allocate, free and checks: the beat is latched, then the result is committed to the result register
// find next scans from the start slot up to and including the first allocated slot, or
// up to the high-water mark when nothing is found, then commits its result
// free all sweeps the allocation bitmap from slot zero to the high-water mark, one slot per cycle
// throughput: one item at a time; a stalled result holds the block until it is taken
// reset: synchronous active-high rst empties the pool, keys restart at one
module generational_handle_pool_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [63:0] handle,
  input  logic [7:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] handle_out,
  output logic [7:0]  index_out,
  output logic [8:0]  live_count
);
  import ghp_pkg::*;

  ghp_cmd_t  cmd;
  ghp_stat_t stat;

  // sequencer
  ghp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot tables and pool registers
  ghp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .handle     (handle),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handle_out (handle_out),
    .index_out  (index_out),
    .live_count (live_count)
  );

endmodule

@@ test/tb_generational_handle_pool_unit.sv @@
module tb_generational_handle_pool_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ghp_pkg::*;

  // operation codes the block must reject
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 300;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SATURATE} load_mix_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] handle;
    logic [7:0]  index;
    logic [8:0]  live;
  } pool_reply_t;

  // shadow of the pool and the replies still owed by the block
  class handle_pool_scoreboard;
    logic [31:0] key_of [HP_SLOTS];
    logic [8:0]  link_of [HP_SLOTS];
    logic [8:0]  free_head;
    logic [8:0]  high_water;
    logic [8:0]  live_total;
    logic [31:0] next_key;
    pool_reply_t awaited_replies[$];
    logic [63:0] issued[$];

    function new();
      foreach (key_of[i]) begin
        key_of[i] = '0;
        link_of[i] = '0;
      end
      free_head = HP_FREE_EMPTY;
      high_water = '0;
      live_total = '0;
      next_key = 32'd1;
    endfunction

    function void push_reply(ghp_status_t st, logic [63:0] hv, int idx);
      pool_reply_t r;
      r.status = st;
      r.handle = (st == RS_OK) ? hv : '0;
      r.index = (st == RS_OK && hv != '0) ? idx[7:0] : '0;
      r.live = live_total;
      awaited_replies.push_back(r);
    endfunction

    function void drop_slot(int idx);
      key_of[idx] = '0;
      link_of[idx] = free_head;
      free_head = idx[8:0];
      live_total = live_total - 1'b1;
    endfunction

    // one random allocated slot, or -1 when the pool is empty
    function int pick_live_slot();
      int start;
      int idx;
      if (live_total == 0) return -1;
      start = $urandom_range(HP_SLOTS - 1);
      for (int n = 0; n < HP_SLOTS; n++) begin
        idx = (start + n) % HP_SLOTS;
        if (key_of[idx] != 0) return idx;
      end
      return -1;
    endfunction

    // advance the shadow pool by one accepted beat
    function void note_request(logic [2:0] op, logic [63:0] h, logic [7:0] si);
      int idx;
      logic [63:0] hv;
      case (op)
        OP_ALLOC: begin
          if (free_head < HP_SLOTS) begin
            idx = int'(free_head);
            free_head = link_of[idx];
          end else if (high_water < HP_SLOTS) begin
            idx = int'(high_water);
            high_water = high_water + 1'b1;
          end else begin
            push_reply(RS_FULL, '0, 0);
            return;
          end
          key_of[idx] = next_key;
          next_key = (next_key == 32'hFFFF_FFFF) ? 32'd1 : next_key + 32'd1;
          live_total = live_total + 1'b1;
          hv = {key_of[idx], 32'(idx)};
          issued.push_back(hv);
          if (issued.size() > 64) void'(issued.pop_front());
          push_reply(RS_OK, hv, idx);
        end
        OP_FREE, OP_CHECK_HANDLE: begin
          if (h[31:0] >= {23'd0, high_water}) begin
            push_reply(RS_RANGE, '0, 0);
            return;
          end
          idx = int'(h[7:0]);
          if (h[63:32] == 0 || key_of[idx] != h[63:32]) begin
            push_reply(RS_STALE, '0, 0);
            return;
          end
          if (op == OP_FREE) drop_slot(idx);
          push_reply(RS_OK, h, idx);
        end
        OP_CHECK_INDEX: begin
          if (si >= high_water) push_reply(RS_RANGE, '0, 0);
          else if (key_of[si] == 0) push_reply(RS_STALE, '0, 0);
          else push_reply(RS_OK, {key_of[si], 24'd0, si}, int'(si));
        end
        OP_FIND_NEXT: begin
          for (idx = int'(si); idx < high_water; idx++) begin
            if (key_of[idx] != 0) begin
              push_reply(RS_OK, {key_of[idx], 32'(idx)}, idx);
              return;
            end
          end
          push_reply(RS_RANGE, '0, 0);
        end
        OP_FREE_ALL: begin
          for (idx = 0; idx < high_water; idx++) begin
            if (key_of[idx] != 0) drop_slot(idx);
          end
          push_reply(RS_OK, '0, 0);
        end
        default: push_reply(RS_RANGE, '0, 0);
      endcase
    endfunction

    // compare one result beat with the oldest owed reply
    function bit check_reply(logic [1:0] st, logic [63:0] ho, logic [7:0] io,
                             logic [8:0] lc, output string msg);
      pool_reply_t e;
      msg = "";
      if (awaited_replies.size() == 0) begin
        msg = $sformatf(" unexpected result status %0d handle %h", st, ho);
        return 1'b0;
      end
      e = awaited_replies.pop_front();
      if (st !== e.status) msg = {msg, $sformatf(" status %0d want %0d", st, e.status)};
      if (ho !== e.handle) msg = {msg, $sformatf(" handle %h want %h", ho, e.handle)};
      if (io !== e.index) msg = {msg, $sformatf(" index %0d want %0d", io, e.index)};
      if (lc !== e.live) msg = {msg, $sformatf(" live %0d want %0d", lc, e.live)};
      return msg == "";
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [63:0] handle = '0;
  logic [7:0]  slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [63:0] handle_out;
  logic [7:0]  index_out;
  logic [8:0]  live_count;

  logic hold_off = 1'b0;
  int send_idle = 6;
  int recv_idle = 88;
  int accepted_beats = 0;
  int mismatches = 0;
  handle_pool_scoreboard sb = new();

  generational_handle_pool_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .handle     (handle),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handle_out (handle_out),
    .index_out  (index_out),
    .live_count (live_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t:%s", $realtime, what);
    mismatches++;
  endtask

  // result check first, then the input beat, then the next stall
  always @(posedge clk) begin
    string msg;
    if (!rst && out_valid && !out_stall) begin
      if (!sb.check_reply(status, handle_out, index_out, live_count, msg))
        report_mismatch(msg);
    end
    if (!rst && in_valid && !in_stall) begin
      sb.note_request(operation, handle, slot_index);
      accepted_beats++;
    end
    out_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (accepted_beats < 620) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one beat, return once it is taken; valid stays high
  task automatic send_beat(logic [2:0] op, logic [63:0] h, logic [7:0] si);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    handle <= h;
    slot_index <= si;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_beat(load_mix_t mix);
    int alloc_pct;
    int free_pct;
    int r;
    int slot;
    logic [2:0]  op;
    logic [63:0] h;
    logic [7:0]  si;
    case (mix)
      MIX_FILL: begin
        alloc_pct = 70;
        free_pct = 12;
      end
      MIX_DRAIN: begin
        alloc_pct = 15;
        free_pct = 50;
      end
      MIX_EVEN: begin
        alloc_pct = 40;
        free_pct = 30;
      end
      default: begin
        alloc_pct = 96;
        free_pct = 2;
      end
    endcase

    // operation mix
    r = $urandom_range(99);
    if (r < alloc_pct) op = OP_ALLOC;
    else if (r < alloc_pct + free_pct) op = OP_FREE;
    else begin
      r = $urandom_range(19);
      if (r < 6) op = OP_CHECK_HANDLE;
      else if (r < 11) op = OP_CHECK_INDEX;
      else if (r < 17) op = OP_FIND_NEXT;
      else if (r == 17) op = (mix == MIX_DRAIN) ? OP_FREE_ALL : OP_FIND_NEXT;
      else if (r == 18) op = OP_UNUSED_6;
      else op = OP_UNUSED_7;
    end

    // handle: mostly live, some old ones, some noise and extremes
    slot = sb.pick_live_slot();
    h = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r < 6 && slot >= 0) h = {sb.key_of[slot], 32'(slot)};
    else if (r < 8 && sb.issued.size() > 0) h = sb.issued[$urandom_range(sb.issued.size() - 1)];
    else if (r == 9) begin
      case ($urandom_range(3))
        0: h = 64'hFFFF_FFFF_FFFF_FFFF;
        1: h = '0;
        2: h = {$urandom, 32'h0000_0100};
        default: h = {$urandom, 24'd0, 8'($urandom_range(255))};
      endcase
    end

    // slot index: live slot, up to the high-water mark, or anywhere
    si = 8'($urandom_range(255));
    r = $urandom_range(3);
    if (r < 2 && slot >= 0) si = 8'(slot);
    else if (r == 2) si = 8'($urandom_range(sb.high_water));

    send_beat(op, h, si);
  endtask

  task automatic run_phase(int beats, bit saturate_first);
    int done;
    int len;
    load_mix_t mix;
    done = 0;
    // drive the pool to full and keep knocking on it
    if (saturate_first) begin
      repeat (290) random_beat(MIX_SATURATE);
      done = 290;
    end
    while (done < beats) begin
      case ($urandom_range(2))
        0: mix = MIX_FILL;
        1: mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      len = $urandom_range(20, 80);
      repeat (len) random_beat(mix);
      done += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty pool: everything out of range but the free all
    send_beat(OP_CHECK_HANDLE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    send_beat(OP_CHECK_INDEX, 64'd0, 8'd0);
    send_beat(OP_FIND_NEXT, 64'd0, 8'd0);
    send_beat(OP_FREE_ALL, 64'd0, 8'd0);
    send_beat(OP_FREE, 64'd0, 8'd0);
    // first allocations from the high-water mark
    send_beat(OP_ALLOC, 64'd0, 8'd0);
    send_beat(OP_ALLOC, 64'd0, 8'd0);
    send_beat(OP_ALLOC, 64'd0, 8'd0);
    // good, zero and wrong keys
    send_beat(OP_CHECK_HANDLE, {32'd2, 32'd1}, 8'd0);
    send_beat(OP_CHECK_HANDLE, {32'd0, 32'd1}, 8'd0);
    send_beat(OP_CHECK_HANDLE, {32'hFFFF_FFFF, 32'd1}, 8'd0);
    // free, then double free
    send_beat(OP_FREE, {32'd2, 32'd1}, 8'd0);
    send_beat(OP_FREE, {32'd2, 32'd1}, 8'd0);
    send_beat(OP_CHECK_INDEX, 64'd0, 8'd1);
    send_beat(OP_CHECK_INDEX, 64'd0, 8'd2);
    send_beat(OP_CHECK_INDEX, 64'd0, 8'd255);
    send_beat(OP_FIND_NEXT, 64'd0, 8'd1);
    send_beat(OP_FIND_NEXT, 64'd0, 8'd255);
    // reuse from the free list
    send_beat(OP_ALLOC, 64'd0, 8'd0);
    send_beat(OP_UNUSED_6, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
    send_beat(OP_UNUSED_7, 64'd0, 8'd0);
    send_beat(OP_FREE_ALL, 64'd0, 8'd0);
    send_beat(OP_ALLOC, 64'd0, 8'd0);
    // huge index whose low bits name a live slot
    send_beat(OP_CHECK_HANDLE, 64'h0000_0005_FFFF_FF02, 8'd0);

    // random part across the idle patterns
    run_phase(220, 1'b0);
    send_idle = 88;
    recv_idle = 6;
    run_phase(220, 1'b0);
    send_idle = 0;
    recv_idle = 0;
    run_phase(320, 1'b1);

    // let the pipe drain, then settle
    in_valid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
